FILE: hdl/complex_arithmetic_compare_unit_core_assert.svh
// Assertion macros shared by the complex arithmetic and compare unit.
`ifndef COMPLEX_ARITHMETIC_COMPARE_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_COMPARE_UNIT_CORE_ASSERT_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define CACU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define CACU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cacu_pkg.sv
// Shared types, mode codes and the divider step of the complex arithmetic unit.
package cacu_pkg;

    localparam int unsigned WORD   = 32;
    // Quotient bits produced by the divider; one more than a word so saturation is exact.
    localparam int unsigned QB     = 33;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_SUB = 4'd1;
    localparam logic [3:0] MODE_MUL = 4'd2;
    localparam logic [3:0] MODE_DIV = 4'd3;
    localparam logic [3:0] MODE_EQ  = 4'd4;
    localparam logic [3:0] MODE_NE  = 4'd5;
    localparam logic [3:0] MODE_LT  = 4'd6;
    localparam logic [3:0] MODE_LE  = 4'd7;
    localparam logic [3:0] MODE_GT  = 4'd8;
    localparam logic [3:0] MODE_GE  = 4'd9;
    localparam logic [3:0] MODE_MIN = 4'd10;
    localparam logic [3:0] MODE_MAX = 4'd11;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } t_item;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        cmp;
        logic        dz;
        logic        ovf;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [63:0]   rem;
        logic [QB-1:0] num;
        logic [QB-1:0] quo;
    } t_dlane;

    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] den;
        t_result     res;
        t_dlane      re;
        t_dlane      im;
    } t_dstage;

    // One restoring division step: brings in the next numerator bit, yields one quotient bit.
    function automatic t_dlane div_step(input t_dlane l, input logic [63:0] d);
        t_dlane      o;
        logic [64:0] t;
        o = l;
        t = {l.rem, l.num[QB-1]};
        if (t >= {1'b0, d}) begin
            o.rem = 64'(t - {1'b0, d});
            o.quo = {l.quo[QB-2:0], 1'b1};
        end else begin
            o.rem = t[63:0];
            o.quo = {l.quo[QB-2:0], 1'b0};
        end
        o.num = {l.num[QB-2:0], 1'b0};
        return o;
    endfunction

endpackage

FILE: hdl/cacu_front.sv
// Front end: takes input transfers, sign-extends the operands and hands items to the queue.
module cacu_front #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  logic [3:0]      i_mode,
    input  logic [31:0]     i_ar,
    input  logic [31:0]     i_ai,
    input  logic [31:0]     i_br,
    input  logic [31:0]     i_bi,
    input  cacu_pkg::t_qstat i_qstat,
    output logic            o_push,
    output cacu_pkg::t_item o_item
);
    import cacu_pkg::*;

    localparam int unsigned SH = WORD - DATA_WIDTH;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    function automatic logic signed [31:0] sext(input logic [31:0] x);
        logic signed [31:0] t;
        t = $signed(x << SH);
        return t >>> SH;
    endfunction

    assign o_push   = r_valid && !i_qstat.full;
    assign o_tready = !r_valid || !i_qstat.full;

    always_comb begin
        n_item.mode = i_mode;
        n_item.ar   = sext(i_ar);
        n_item.ai   = sext(i_ai);
        n_item.br   = sext(i_br);
        n_item.bi   = sext(i_bi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

FILE: hdl/cacu_queue.sv
// Short item queue that decouples the front end from the arithmetic back end.
module cacu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cacu_pkg::t_item  i_item,
    input  logic             i_pop,
    output cacu_pkg::t_item  o_item,
    output cacu_pkg::t_qstat o_qstat
);
    import cacu_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;

    assign o_qstat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: hdl/cacu_back.sv
// Back end: multiply, sum, compare and pipelined divide stages, then the output register.
module cacu_back #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cacu_pkg::t_item   i_item,
    input  cacu_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    output cacu_pkg::t_result o_res,
    input  logic              i_ready
);
    import cacu_pkg::*;

    localparam int unsigned NW = 64 + FRAC_BITS;

    logic ce;

    // Stage 1: products, squares and operand sums.
    logic               r_v1;
    logic [3:0]         r1_mode;
    logic signed [31:0] r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [63:0] r1_rr, r1_ii, r1_ri, r1_ir;
    logic signed [63:0] r1_sqar, r1_sqai, r1_sqbr, r1_sqbi;
    logic signed [32:0] r1_sre, r1_sim;
    logic               r1_peq;

    // Stage 2: wide sums and squared magnitudes.
    logic               r_v2;
    logic [3:0]         r2_mode;
    logic signed [31:0] r2_ar, r2_ai, r2_br, r2_bi;
    logic signed [64:0] r2_sre, r2_sim;
    logic [63:0]        r2_ma, r2_mb;
    logic               r2_peq;
    logic signed [64:0] n2_sre, n2_sim;

    // Stage 3: sign and magnitude, magnitude compare, operand pick.
    logic               r_v3;
    logic [3:0]         r3_mode;
    logic               r3_nre, r3_nim;
    logic [63:0]        r3_mre, r3_mim;
    logic               r3_lt, r3_eq, r3_peq;
    logic [63:0]        r3_den;
    logic [31:0]        r3_pre, r3_pim;
    logic               n3_pick;

    // Stage 4 and the divide stages.
    logic               r_dv [QB+1];
    t_dstage            r_ds [QB+1];
    t_dstage            n4;

    logic               r_out_v;
    t_result            r_out;
    t_result            n_out;

    function automatic logic [32:0] sat_to(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        logic [63:0] m;
        logic        o;
        lim = 64'(1) << (DATA_WIDTH - 1);
        m   = mag;
        o   = 1'b0;
        if (neg) begin
            if (m > lim) begin
                m = lim;
                o = 1'b1;
            end
            m = 64'(0) - m;
        end else if (m > lim - 64'(1)) begin
            m = lim - 64'(1);
            o = 1'b1;
        end
        return {o, m[31:0]};
    endfunction

    function automatic t_dlane div_init(input logic neg, input logic [63:0] mag,
                                        input logic [63:0] d);
        t_dlane        l;
        logic [NW-1:0] n;
        logic [NW-1:0] r0;
        n       = NW'(mag) << FRAC_BITS;
        r0      = n >> QB;
        l.neg   = neg;
        l.ovf   = (r0 >= NW'(d));
        l.rem   = r0[63:0];
        l.num   = n[QB-1:0];
        l.quo   = '0;
        return l;
    endfunction

    assign ce    = !r_out_v || i_ready;
    assign o_pop = ce && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (ce) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_mode <= i_item.mode;
            r1_ar   <= i_item.ar;
            r1_ai   <= i_item.ai;
            r1_br   <= i_item.br;
            r1_bi   <= i_item.bi;
            r1_rr   <= i_item.ar * i_item.br;
            r1_ii   <= i_item.ai * i_item.bi;
            r1_ri   <= i_item.ar * i_item.bi;
            r1_ir   <= i_item.ai * i_item.br;
            r1_sqar <= i_item.ar * i_item.ar;
            r1_sqai <= i_item.ai * i_item.ai;
            r1_sqbr <= i_item.br * i_item.br;
            r1_sqbi <= i_item.bi * i_item.bi;
            if (i_item.mode == MODE_SUB) begin
                r1_sre <= i_item.ar - i_item.br;
                r1_sim <= i_item.ai - i_item.bi;
            end else begin
                r1_sre <= i_item.ar + i_item.br;
                r1_sim <= i_item.ai + i_item.bi;
            end
            r1_peq  <= (i_item.ar == i_item.br) && (i_item.ai == i_item.bi);
        end
    end

    always_comb begin
        unique case (r1_mode) inside
            MODE_ADD, MODE_SUB: begin
                n2_sre = {{32{r1_sre[32]}}, r1_sre};
                n2_sim = {{32{r1_sim[32]}}, r1_sim};
            end
            MODE_MUL: begin
                n2_sre = {r1_rr[63], r1_rr} - {r1_ii[63], r1_ii};
                n2_sim = {r1_ri[63], r1_ri} + {r1_ir[63], r1_ir};
            end
            MODE_DIV: begin
                n2_sre = {r1_rr[63], r1_rr} + {r1_ii[63], r1_ii};
                n2_sim = {r1_ir[63], r1_ir} - {r1_ri[63], r1_ri};
            end
            default: begin
                n2_sre = '0;
                n2_sim = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_mode <= r1_mode;
            r2_ar   <= r1_ar;
            r2_ai   <= r1_ai;
            r2_br   <= r1_br;
            r2_bi   <= r1_bi;
            r2_sre  <= n2_sre;
            r2_sim  <= n2_sim;
            r2_ma   <= $unsigned(r1_sqar) + $unsigned(r1_sqai);
            r2_mb   <= $unsigned(r1_sqbr) + $unsigned(r1_sqbi);
            r2_peq  <= r1_peq;
        end
    end

    assign n3_pick = (r2_mode == MODE_MIN) ? (r2_ma <= r2_mb) : (r2_ma >= r2_mb);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_mode <= r2_mode;
            r3_nre  <= r2_sre[64];
            r3_nim  <= r2_sim[64];
            r3_mre  <= r2_sre[64] ? 64'(65'(0) - r2_sre) : r2_sre[63:0];
            r3_mim  <= r2_sim[64] ? 64'(65'(0) - r2_sim) : r2_sim[63:0];
            r3_lt   <= (r2_ma < r2_mb);
            r3_eq   <= (r2_ma == r2_mb);
            r3_peq  <= r2_peq;
            r3_den  <= r2_mb;
            r3_pre  <= n3_pick ? r2_ar : r2_br;
            r3_pim  <= n3_pick ? r2_ai : r2_bi;
        end
    end

    // Stage 4 settles every mode but divide and loads the two divider lanes.
    always_comb begin
        logic [32:0] s_re;
        logic [32:0] s_im;
        n4.mode = r3_mode;
        n4.den  = r3_den;
        n4.res  = '0;
        n4.re   = div_init(r3_nre, r3_mre, r3_den);
        n4.im   = div_init(r3_nim, r3_mim, r3_den);
        s_re    = '0;
        s_im    = '0;
        unique case (r3_mode) inside
            MODE_ADD, MODE_SUB: begin
                s_re        = sat_to(r3_nre, r3_mre);
                s_im        = sat_to(r3_nim, r3_mim);
                n4.res.re   = s_re[31:0];
                n4.res.im   = s_im[31:0];
                n4.res.ovf  = s_re[32] || s_im[32];
            end
            MODE_MUL: begin
                s_re        = sat_to(r3_nre, r3_mre >> FRAC_BITS);
                s_im        = sat_to(r3_nim, r3_mim >> FRAC_BITS);
                n4.res.re   = s_re[31:0];
                n4.res.im   = s_im[31:0];
                n4.res.ovf  = s_re[32] || s_im[32];
            end
            MODE_DIV: n4.res.dz = (r3_den == '0);
            MODE_EQ:  n4.res.cmp = r3_peq;
            MODE_NE:  n4.res.cmp = !r3_peq;
            MODE_LT:  n4.res.cmp = r3_lt;
            MODE_LE:  n4.res.cmp = r3_lt || r3_eq;
            MODE_GT:  n4.res.cmp = !r3_lt && !r3_eq;
            MODE_GE:  n4.res.cmp = !r3_lt;
            MODE_MIN, MODE_MAX: begin
                n4.res.re = r3_pre;
                n4.res.im = r3_pim;
            end
            default: n4.res = '0;
        endcase
    end

    // Valid flags of stage 4 and of every divider stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (ce) begin
            r_dv[0] <= r_v3;
            for (int k = 0; k < QB; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    // Each divider stage carries the item along and adds one quotient bit per lane.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ds[0] <= n4;
            for (int k = 0; k < QB; k++) begin
                r_ds[k+1].mode <= r_ds[k].mode;
                r_ds[k+1].den  <= r_ds[k].den;
                r_ds[k+1].res  <= r_ds[k].res;
                r_ds[k+1].re   <= div_step(r_ds[k].re, r_ds[k].den);
                r_ds[k+1].im   <= div_step(r_ds[k].im, r_ds[k].den);
            end
        end
    end

    always_comb begin
        logic [32:0] s_re;
        logic [32:0] s_im;
        s_re  = sat_to(r_ds[QB].re.neg, r_ds[QB].re.ovf ? '1 : 64'(r_ds[QB].re.quo));
        s_im  = sat_to(r_ds[QB].im.neg, r_ds[QB].im.ovf ? '1 : 64'(r_ds[QB].im.quo));
        n_out = r_ds[QB].res;
        if (r_ds[QB].mode == MODE_DIV && !r_ds[QB].res.dz) begin
            n_out.re  = s_re[31:0];
            n_out.im  = s_im[31:0];
            n_out.ovf = s_re[32] || s_im[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_out_v <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

FILE: hdl/complex_arithmetic_compare_unit_core.sv
// Top level of the complex arithmetic and compare unit: front end, queue and back end.
//
// Each input transfer on the slave stream carries two complex operands in tdata and a
// mode in tuser. Each yields exactly one output transfer on the master stream, in order,
// with the two result parts in tdata and the compare, zero-divisor and overflow flags
// in tuser. Operands are signed fixed point with DATA_WIDTH bits of which FRAC_BITS
// are fraction bits; only the low DATA_WIDTH bits of each operand word are used.
// Throughput is one transfer per clock in both directions when the receiver is ready.
// An input transfer passes the front register, the queue, four arithmetic stages
// (multipliers, wide sums, magnitudes, saturation) and 33 restoring divider stages
// (one quotient bit each), after which the result sits in the output register. Every
// item flows through the divider stages so that order is kept without reordering logic.
// When tready is low while an output is valid, the whole back pipeline holds; the queue
// then fills and the slave tready drops once it and the front register are full.
// The synchronous active-low reset empties the queue and clears all valid flags; no
// clearing pass is needed and the block accepts transfers right after reset.
module complex_arithmetic_compare_unit_core #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_real [31:0], a_imag [63:32], b_real [95:64], b_imag [127:96]
    input  logic [127:0] i_s_axis_tdata,
    // mode [3:0]
    input  logic [3:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // res_real [31:0], res_imag [63:32]
    output logic [63:0]  o_m_axis_tdata,
    // cmp_true [0], div_zero [1], overflowed [2]
    output logic [2:0]   o_m_axis_tuser
);
    import cacu_pkg::*;

    t_item   w_front_item;
    t_item   w_queue_item;
    t_qstat  w_qstat;
    t_result w_res;
    logic    w_push;
    logic    w_pop;
    logic    w_data_zero;
    logic    w_dz_clean;
    logic    w_cmp_clean;

    // Front end registers the transfer and sign-extends operands.
    cacu_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_mode   (i_s_axis_tuser),
        .i_ar     (i_s_axis_tdata[31:0]),
        .i_ai     (i_s_axis_tdata[63:32]),
        .i_br     (i_s_axis_tdata[95:64]),
        .i_bi     (i_s_axis_tdata[127:96]),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    // The queue lets the front keep taking transfers while the back end is held.
    cacu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_qstat (w_qstat)
    );

    // The back end does all arithmetic and owns the output register.
    cacu_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_queue_item),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .o_res   (w_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {w_res.im, w_res.re};
    assign o_m_axis_tuser = {w_res.ovf, w_res.dz, w_res.cmp};

    // Output properties checked below.
    assign w_data_zero = (o_m_axis_tdata == '0);
    assign w_dz_clean  = w_data_zero && !w_res.ovf && !w_res.cmp;
    assign w_cmp_clean = w_data_zero && !w_res.dz && !w_res.ovf;

`include "complex_arithmetic_compare_unit_core_assert.svh"

    // A zero divisor gives a zero result with no other flag.
    `CACU_ASSERT_IMP(a_dz_clean, o_m_axis_tvalid && w_res.dz, w_dz_clean, "zero divisor not clean")
    // A true compare never carries result data.
    `CACU_ASSERT_IMP(a_cmp_clean, o_m_axis_tvalid && w_res.cmp, w_cmp_clean, "compare has data")
    // A held output freezes the back end, so nothing leaves the queue.
    `CACU_ASSERT_IMP(a_hold_no_pop, o_m_axis_tvalid && !i_m_axis_tready, !w_pop, "pop while held")
    // A write without a read leaves the queue non-empty.
    `CACU_ASSERT_NEXT(a_push_fills, w_push && !w_pop, !w_qstat.empty, "queue empty after push")

endmodule

FILE: tb/sv/complex_arithmetic_compare_unit_core_tb.sv
// Self-checking testbench for the complex arithmetic and compare unit core.
module complex_arithmetic_compare_unit_core_tb;
    import cacu_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned RANDOM_ITEMS = 1730;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // a_real [31:0], a_imag [63:32], b_real [95:64], b_imag [127:96]
    logic [127:0] i_s_axis_tdata;
    // mode [3:0]
    logic [3:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // res_real [31:0], res_imag [63:32]
    logic [63:0]  o_m_axis_tdata;
    // cmp_true [0], div_zero [1], overflowed [2]
    logic [2:0]   o_m_axis_tuser;

    complex_arithmetic_compare_unit_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_item       operand_queue[$];
    t_result     expected_results[$];
    t_item       item_in_flight;
    logic        in_fire = 1'b0;
    logic        out_fire;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned cycle_count = 0;
    bit          stimulus_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clamp an exact value to a signed 32-bit word and note any clipping.
    function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Exact expected output of one operation; all intermediates are 128 bits wide.
    function automatic t_result complex_op(input t_item it);
        t_result             r;
        logic signed [127:0] ar, ai, br, bi, mag_a, mag_b, num_re, num_im;
        logic                pick_a;
        ar = 128'(it.ar);
        ai = 128'(it.ai);
        br = 128'(it.br);
        bi = 128'(it.bi);
        mag_a = ar * ar + ai * ai;
        mag_b = br * br + bi * bi;
        r = '0;
        case (it.mode)
            MODE_ADD: begin
                r.re = clamp_word(ar + br, r.ovf);
                r.im = clamp_word(ai + bi, r.ovf);
            end
            MODE_SUB: begin
                r.re = clamp_word(ar - br, r.ovf);
                r.im = clamp_word(ai - bi, r.ovf);
            end
            MODE_MUL: begin
                // Signed division truncates toward zero, matching the shift rule.
                r.re = clamp_word((ar * br - ai * bi) / 128'sd65536, r.ovf);
                r.im = clamp_word((ar * bi + ai * br) / 128'sd65536, r.ovf);
            end
            MODE_DIV: begin
                if (mag_b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num_re = (ar * br + ai * bi) * 128'sd65536;
                    num_im = (br * ai - bi * ar) * 128'sd65536;
                    r.re = clamp_word(num_re / mag_b, r.ovf);
                    r.im = clamp_word(num_im / mag_b, r.ovf);
                end
            end
            MODE_EQ: r.cmp = (ar == br) && (ai == bi);
            MODE_NE: r.cmp = (ar != br) || (ai != bi);
            MODE_LT: r.cmp = mag_a < mag_b;
            MODE_LE: r.cmp = mag_a <= mag_b;
            MODE_GT: r.cmp = mag_a > mag_b;
            MODE_GE: r.cmp = mag_a >= mag_b;
            MODE_MIN, MODE_MAX: begin
                pick_a = (it.mode == MODE_MIN) ? (mag_a <= mag_b) : (mag_a >= mag_b);
                r.re = pick_a ? it.ar : it.br;
                r.im = pick_a ? it.ai : it.bi;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            3: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [3:0] m, input logic [31:0] ar, input logic [31:0] ai,
                            input logic [31:0] br, input logic [31:0] bi);
        t_item it;
        it.mode = m;
        it.ar = ar;
        it.ai = ai;
        it.br = br;
        it.bi = bi;
        operand_queue.push_back(it);
    endtask

    // Take a gap with a chance of 24 in a hundred, except during a quiet window mid-run.
    function automatic bit take_gap();
        if (cycle_count > 700 && cycle_count < 1100) return 1'b0;
        return $urandom_range(0, 99) < 24;
    endfunction

    // Stimulus: directed corner cases first, then random operations.
    initial begin
        logic [31:0] x, y;
        logic [3:0]  m;
        queue_op(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
        queue_op(MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
        queue_op(MODE_ADD, 32'h0001_0000, 32'hfffe_0000, 32'h0000_8000, 32'h0000_0000);
        queue_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        queue_op(MODE_MUL, 32'h0001_8000, 32'hffff_0000, 32'h0002_0000, 32'h0000_0003);
        queue_op(MODE_MUL, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
        queue_op(MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
        queue_op(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        queue_op(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_op(MODE_DIV, 32'h0003_0000, 32'hfffc_0000, 32'h0001_0000, 32'h0002_0000);
        queue_op(MODE_DIV, 32'hffff_fffd, 32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_op(MODE_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
        queue_op(MODE_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h7fff_ffff);
        queue_op(MODE_NE, 32'h0000_0005, 32'h0000_0006, 32'h0000_0005, 32'h0000_0006);
        queue_op(MODE_NE, 32'h0000_0005, 32'h0000_0006, 32'h0000_0006, 32'h0000_0006);
        // Most of these use equal magnitudes with different parts to probe the tie cases.
        queue_op(MODE_LT, 32'h0000_0003, 32'h0000_0004, 32'hffff_fffb, 32'h0000_0000);
        queue_op(MODE_LE, 32'h0000_0003, 32'h0000_0004, 32'hffff_fffb, 32'h0000_0000);
        queue_op(MODE_GT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_op(MODE_GE, 32'h0000_0003, 32'h0000_0004, 32'h0000_0000, 32'h0000_0005);
        queue_op(MODE_MIN, 32'h0000_0003, 32'h0000_0004, 32'hffff_fffb, 32'h0000_0000);
        queue_op(MODE_MAX, 32'h0000_0003, 32'h0000_0004, 32'hffff_fffb, 32'h0000_0000);
        queue_op(MODE_MIN, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
        queue_op(MODE_MAX, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
        queue_op(4'd12, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_op(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
            x = random_operand();
            y = random_operand();
            case ($urandom_range(0, 9))
                // Same operands drive equality true and magnitude ties.
                0: queue_op(m, x, y, x, y);
                1: queue_op(m, x, y, ~x + 32'd1, y);
                2: queue_op(m, x, y, y, x);
                3: queue_op(m, x, y, 32'd0, 32'd0);
                default: queue_op(m, x, y, random_operand(), random_operand());
            endcase
        end
        stimulus_done = 1'b1;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Handshake capture and result checking at the rising edge.
    always @(posedge i_clk) begin
        t_result want;
        logic [31:0] got_re, got_im;
        cycle_count <= cycle_count + 1;
        in_fire <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_fire = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        if ((i_rst_n && i_s_axis_tvalid && o_s_axis_tready) || out_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (out_fire) begin
            got_re = o_m_axis_tdata[31:0];
            got_im = o_m_axis_tdata[63:32];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", got_re, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (got_re !== want.re) report_mismatch("res_real", got_re, want.re);
                if (got_im !== want.im) report_mismatch("res_imag", got_im, want.im);
                if (o_m_axis_tuser[0] !== want.cmp)
                    report_mismatch("cmp_true", 32'(o_m_axis_tuser[0]), 32'(want.cmp));
                if (o_m_axis_tuser[1] !== want.dz)
                    report_mismatch("div_zero", 32'(o_m_axis_tuser[1]), 32'(want.dz));
                if (o_m_axis_tuser[2] !== want.ovf)
                    report_mismatch("overflowed", 32'(o_m_axis_tuser[2]), 32'(want.ovf));
            end
        end
    end

    // Driver and receiver readiness, updated at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                // The transfer seen at the last rising edge is now predicted and retired.
                expected_results.push_back(complex_op(item_in_flight));
            end
            if ((!i_s_axis_tvalid || in_fire) && operand_queue.size() != 0 && !take_gap()) begin
                item_in_flight = operand_queue.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser <= item_in_flight.mode;
                i_s_axis_tdata <= {item_in_flight.bi, item_in_flight.br,
                                   item_in_flight.ai, item_in_flight.ar};
            end else if (in_fire) begin
                i_s_axis_tvalid <= 1'b0;
            end
            i_m_axis_tready <= !take_gap();
        end
    end

    initial begin
        wait (i_rst_n);
        fork
            begin
                wait (stimulus_done && operand_queue.size() == 0 && !i_s_axis_tvalid
                      && !in_fire && expected_results.size() == 0);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                if (error_count == 0)
                    $display("DONE: 0 errors");
                else
                    $display("DONE: errors detected");
                $finish;
            end
            begin
                wait (idle_cycles >= STALL_LIMIT);
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        join
    end

endmodule
